// File: sv/signed_decimal_formatter_defines.svh
// Assertion macros for the signed decimal formatter.
// Included by the top level; needs clock and reset in the including scope.
`ifndef SIGNED_DECIMAL_FORMATTER_DEFINES_SVH
`define SIGNED_DECIMAL_FORMATTER_DEFINES_SVH

// check a condition in the cycle after a trigger
`define SDF_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("sdf: condition after trigger not met");

// check a condition in the same cycle as a trigger
`define SDF_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("sdf: condition with trigger not met");

`endif

// File: sv/sdf_pkg.sv
// Shared types, constants and helpers of the signed decimal formatter.
// No dependencies; used by sdf_ctrl, sdf_datapath and the top level.
package sdf_pkg;

   localparam int MAX_FIELD  = 62;
   localparam int NUM_DIGITS = 10;
   localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);

   localparam logic [1:0] LEN_INT   = 2'd0;
   localparam logic [1:0] LEN_SHORT = 2'd1;
   localparam logic [1:0] LEN_CHAR  = 2'd2;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;

   // reciprocal of ten, scaled by 2^35
   localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_SIZE,
      ST_LPAD,
      ST_SIGN,
      ST_ZPAD,
      ST_PZERO,
      ST_DIGIT,
      ST_RPAD
   } sdf_state_type;

   typedef struct packed {
      logic          capture;
      logic          div_step;
      logic          size;
      logic          cnt_load;
      logic          emit;
      sdf_state_type phase;
   } sdf_cmd_type;

   typedef struct packed {
      logic skip;
      logic div_done;
      logic empty;
      logic cnt_zero;
      logic cnt_one;
      logic last;
      logic out_free;
   } sdf_status_type;

   function automatic logic [5:0] sat_field(input logic [5:0] x);
      sat_field = (x > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : x;
   endfunction

   function automatic sdf_state_type next_phase(input sdf_state_type s);
      case (s)
         ST_LPAD:  next_phase = ST_SIGN;
         ST_SIGN:  next_phase = ST_ZPAD;
         ST_ZPAD:  next_phase = ST_PZERO;
         ST_PZERO: next_phase = ST_DIGIT;
         ST_DIGIT: next_phase = ST_RPAD;
         default:  next_phase = ST_IDLE;
      endcase
   endfunction

endpackage

// File: sv/sdf_datapath.sv
// Datapath of the signed decimal formatter: operand capture, digit extraction,
// field sizing, phase counter and output register. Depends on sdf_pkg.
module sdf_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [55:0]            req_tdata,
   input  logic [1:0]             req_tuser,
   input  sdf_pkg::sdf_cmd_type   cmd,
   output sdf_pkg::sdf_status_type status,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast
);

   logic [31:0] raw;
   logic [31:0] narrow;
   logic        neg_in;
   logic [31:0] mag_in;

   logic [31:0] mag_ff;
   logic        neg_ff, plus_ff, space_ff, left_ff, zpad_ff, has_prec_ff, skip_ff;
   logic [5:0]  width_ff, prec_ff;
   logic [3:0]  nd_ff;
   logic [3:0]  digits_ff [sdf_pkg::NUM_DIGITS];
   logic [5:0]  cnt_ff, cnt_in;
   logic [5:0]  remain_ff;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_char_ff;
   logic        rsp_last_ff;

   logic [63:0] prod;
   logic [31:0] quot, quot_x10, rem;

   logic        sign_len;
   logic [5:0]  pz_len, pad_len, lpad_len, zpad_len, rpad_len;
   logic [6:0]  body_len, total_len;
   logic        zp_mode;
   logic [7:0]  sign_char, emit_char;
   logic [sdf_pkg::DIGIT_IDX_W-1:0] digit_idx;
   sdf_pkg::sdf_state_type cnt_phase;

   // narrow and take magnitude
   always_comb begin
      raw = req_tdata[31:0];
      case (req_tuser)
         sdf_pkg::LEN_SHORT: narrow = {{16{raw[15]}}, raw[15:0]};
         sdf_pkg::LEN_CHAR:  narrow = {{24{raw[7]}}, raw[7:0]};
         default:            narrow = raw;
      endcase
      neg_in = narrow[31];
      mag_in = neg_in ? (~narrow + 32'd1) : narrow;
   end

   // one decimal digit per step
   always_comb begin
      prod     = {32'd0, mag_ff} * {32'd0, sdf_pkg::DIV10_RECIP};
      quot     = {3'd0, prod[63:35]};
      quot_x10 = {quot[28:0], 3'd0} + {quot[30:0], 1'b0};
      rem      = mag_ff - quot_x10;
   end

   // field sizing
   always_comb begin
      sign_len  = neg_ff | plus_ff | space_ff;
      pz_len    = (has_prec_ff && (prec_ff > {2'd0, nd_ff})) ? (prec_ff - {2'd0, nd_ff}) : 6'd0;
      body_len  = {6'd0, sign_len} + {1'b0, pz_len} + {3'd0, nd_ff};
      pad_len   = ({1'b0, width_ff} > body_len) ? 6'({1'b0, width_ff} - body_len) : 6'd0;
      total_len = {1'b0, pad_len} + body_len;
      zp_mode   = !left_ff && zpad_ff && !has_prec_ff;
      lpad_len  = (!left_ff && !zp_mode) ? pad_len : 6'd0;
      zpad_len  = zp_mode ? pad_len : 6'd0;
      rpad_len  = left_ff ? pad_len : 6'd0;
      if (neg_ff) begin
         sign_char = sdf_pkg::CH_MINUS;
      end else if (plus_ff) begin
         sign_char = sdf_pkg::CH_PLUS;
      end else begin
         sign_char = sdf_pkg::CH_SPACE;
      end
   end

   always_comb begin
      digit_idx = cnt_ff[sdf_pkg::DIGIT_IDX_W-1:0] - sdf_pkg::DIGIT_IDX_W'(1);
      case (cmd.phase) inside
         sdf_pkg::ST_SIGN:  emit_char = sign_char;
         sdf_pkg::ST_ZPAD,
         sdf_pkg::ST_PZERO: emit_char = sdf_pkg::CH_ZERO;
         sdf_pkg::ST_DIGIT: emit_char = sdf_pkg::CH_ZERO | {4'd0, digits_ff[digit_idx]};
         default:           emit_char = sdf_pkg::CH_SPACE;
      endcase
   end

   // select the phase length to load: the commanded phase, or the following one when an item goes out
   always_comb begin
      cnt_phase = cmd.emit ? sdf_pkg::next_phase(cmd.phase) : cmd.phase;
      case (cnt_phase)
         sdf_pkg::ST_LPAD:  cnt_in = lpad_len;
         sdf_pkg::ST_SIGN:  cnt_in = {5'd0, sign_len};
         sdf_pkg::ST_ZPAD:  cnt_in = zpad_len;
         sdf_pkg::ST_PZERO: cnt_in = pz_len;
         sdf_pkg::ST_DIGIT: cnt_in = {2'd0, nd_ff};
         sdf_pkg::ST_RPAD:  cnt_in = rpad_len;
         default:           cnt_in = 6'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mag_ff      <= mag_in;
         neg_ff      <= neg_in;
         width_ff    <= sdf_pkg::sat_field(req_tdata[37:32]);
         has_prec_ff <= req_tdata[38];
         prec_ff     <= sdf_pkg::sat_field(req_tdata[44:39]);
         left_ff     <= req_tdata[45];
         plus_ff     <= req_tdata[46];
         space_ff    <= req_tdata[47];
         zpad_ff     <= req_tdata[48];
         skip_ff     <= req_tdata[38] && (req_tdata[44:39] == 6'd0) && (mag_in == 32'd0);
         nd_ff       <= 4'd0;
      end else if (cmd.div_step) begin
         digits_ff[nd_ff[sdf_pkg::DIGIT_IDX_W-1:0]] <= rem[3:0];
         nd_ff  <= nd_ff + 4'd1;
         mag_ff <= quot;
      end
      if (cmd.cnt_load) begin
         cnt_ff <= cnt_in;
      end else if (cmd.emit) begin
         cnt_ff <= cnt_ff - 6'd1;
      end
      if (cmd.size) begin
         remain_ff <= total_len[5:0];
      end else if (cmd.emit) begin
         remain_ff <= remain_ff - 6'd1;
      end
      if (cmd.emit) begin
         rsp_char_ff <= emit_char;
         rsp_last_ff <= (remain_ff == 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      status.skip     = skip_ff;
      status.div_done = (quot == 32'd0);
      status.empty    = (total_len == 7'd0);
      status.cnt_zero = (cnt_ff == 6'd0);
      status.cnt_one  = (cnt_ff == 6'd1);
      status.last     = (remain_ff == 6'd1);
      status.out_free = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: sv/sdf_ctrl.sv
// Controller of the signed decimal formatter: sequences capture, digit steps,
// sizing and the output phases. Depends on sdf_pkg.
module sdf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  sdf_pkg::sdf_status_type status,
   output sdf_pkg::sdf_cmd_type   cmd
);

   sdf_pkg::sdf_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.phase  = state_ff;
      unique case (state_ff) inside
         sdf_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = sdf_pkg::ST_DIV;
            end
         end
         sdf_pkg::ST_DIV: begin
            if (status.skip) begin
               state_in = sdf_pkg::ST_SIZE;
            end else begin
               cmd.div_step = 1'b1;
               if (status.div_done) begin
                  state_in = sdf_pkg::ST_SIZE;
               end
            end
         end
         sdf_pkg::ST_SIZE: begin
            cmd.size     = 1'b1;
            cmd.cnt_load = 1'b1;
            cmd.phase    = sdf_pkg::ST_LPAD;
            state_in     = status.empty ? sdf_pkg::ST_IDLE : sdf_pkg::ST_LPAD;
         end
         sdf_pkg::ST_LPAD, sdf_pkg::ST_SIGN, sdf_pkg::ST_ZPAD,
         sdf_pkg::ST_PZERO, sdf_pkg::ST_DIGIT, sdf_pkg::ST_RPAD: begin
            if (status.cnt_zero) begin
               state_in     = sdf_pkg::next_phase(state_ff);
               cmd.cnt_load = 1'b1;
               cmd.phase    = sdf_pkg::next_phase(state_ff);
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last) begin
                  state_in = sdf_pkg::ST_IDLE;
               end else if (status.cnt_one) begin
                  state_in     = sdf_pkg::next_phase(state_ff);
                  cmd.cnt_load = 1'b1;
               end
            end
         end
         default: begin
            state_in = sdf_pkg::ST_IDLE;
         end
      endcase
      // load the next phase length while the current one emits its final item
      if (cmd.emit && cmd.cnt_load) begin
         cmd.emit  = 1'b1;
      end
   end

endmodule

// File: sv/signed_decimal_formatter.sv
// Signed decimal formatter: one printf %d conversion per item, one character per result.
// Sequence: capture, one digit step per digit (one step when there are no digits),
// sizing, then one character per cycle while the output is free; each empty output
// phase before the last character takes a step of its own. The digit loop does one
// multiply by a tenth per cycle; a new item is taken only after the last character.
// Reset (synchronous, high) returns the controller to idle and empties the output register.
`include "signed_decimal_formatter_defines.svh"
module signed_decimal_formatter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // value[31:0], field_width[37:32], has_precision[38], min_digits[44:39],
   // left_justify[45], force_plus[46], space_sign[47], zero_pad[48], zeros[55:49]
   input  logic [55:0] req_tdata,
   // length_mode[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_char[7:0]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);

   sdf_pkg::sdf_cmd_type    cmd;
   sdf_pkg::sdf_status_type status;

   sdf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sdf_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `SDF_ASSERT_NEXT(a_one_item_at_a_time, req_tvalid && req_tready, !req_tready)
   `SDF_ASSERT_SAME(a_emit_into_free_slot, cmd.emit, status.out_free)
   `SDF_ASSERT_NEXT(a_last_returns_idle, cmd.emit && status.last, req_tready)

endmodule
